/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the weighted category pick block.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define WCP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wcp assertion failed");

// Plain invariant checked at every rising edge outside reset.
`define WCP_ASSERT_ALW(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("wcp invariant failed");

`endif

/* rtl/wcp_pkg.sv */
// Types and constants of the weighted category pick block.
// Depends on nothing; used by the interfaces and all modules.
package wcp_pkg;

  localparam int CAT_W    = 8;
  localparam int KEY_W    = 32;
  localparam int CODE_W   = 32;
  localparam int RND_W    = 31;
  localparam int WEIGHT_W = 7;
  localparam int BIT_W    = 5;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_PICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADCAT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // What the back end has to do with a classified item.
  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_ADD    = 2'd2,
    OP_PICK   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                   op;
    status_t               status;
    logic [CAT_W-1:0]      cat;
    logic [WEIGHT_W-1:0]   weight;
    logic [CODE_W-1:0]     code;
    logic [RND_W-1:0]      rnd;
  } cmd_t;

  typedef struct packed {
    logic [CAT_W-1:0]  cat;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } entry_t;

endpackage

/* rtl/wcp_in_if.sv */
// Input channel of the weighted category pick block: valid, ready and one item.
// Depends on wcp_pkg for field widths.
interface wcp_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [2:0]                    grade;
  logic [4:0]                    slot;
  logic [wcp_pkg::WEIGHT_W-1:0]  weight;
  logic signed [wcp_pkg::CODE_W-1:0] entry_code;
  logic [wcp_pkg::RND_W-1:0]     random_value;

  modport source (output valid, kind, grade, slot, weight, entry_code, random_value,
                  input ready);
  modport sink (input valid, kind, grade, slot, weight, entry_code, random_value,
                output ready);
endinterface

/* rtl/wcp_out_if.sv */
// Result channel of the weighted category pick block: valid, ready and one result.
// Depends on wcp_pkg for field widths.
interface wcp_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [wcp_pkg::CODE_W-1:0] picked_code;

  modport source (output valid, status, picked_code, input ready);
  modport sink (input valid, status, picked_code, output ready);
endinterface

/* rtl/weighted_category_pick_top.sv */
// Weighted category pick. After a command leaves the queue: clear, bad category,
// zero-weight add and unused kinds are answered from the idle state; add and pick of
// an empty category read the category total first; other picks then run the
// bit-serial remainder unit and scan the stored entries (up to 1024) one at a time.
// The back end takes one item at a time; the front queue holds 2 more.
// Reset clears the entry count and the per-category valid bits, so old totals read as zero; no clearing pass is needed.
module weighted_category_pick_top #(
  parameter int MAX_ENTRIES = 1024,
  parameter int NUM_SLOTS   = 17,
  parameter int NUM_GRADES  = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  wcp_in_if.sink      in_ch,
  wcp_out_if.source   out_ch
);

  localparam int NUM_CATS = NUM_GRADES * NUM_SLOTS;

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  wcp_pkg::cmd_t q_cmd;
  wcp_pkg::cmd_t q_head;

  wcp_front #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_GRADES (NUM_GRADES)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  wcp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  wcp_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NUM_CATS    (NUM_CATS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/wcp_front.sv */
// Front end: takes input beats, checks the category and turns each into a command.
// Depends on wcp_pkg and wcp_in_if.
module wcp_front #(
  parameter int NUM_SLOTS  = 17,
  parameter int NUM_GRADES = 5
) (
  wcp_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            q_push,
  output wcp_pkg::cmd_t   q_cmd
);

  logic                       cat_ok;
  logic [wcp_pkg::CAT_W-1:0]  cat;

  assign cat_ok = ({1'b0, in_ch.grade} < 4'(NUM_GRADES)) &&
                  ({1'b0, in_ch.slot} < 6'(NUM_SLOTS));
  assign cat    = wcp_pkg::CAT_W'(in_ch.grade) * wcp_pkg::CAT_W'(NUM_SLOTS) +
                  wcp_pkg::CAT_W'(in_ch.slot);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_cmd        = '0;
    q_cmd.op     = wcp_pkg::OP_REPORT;
    q_cmd.status = wcp_pkg::ST_OK;
    q_cmd.cat    = cat;
    q_cmd.weight = in_ch.weight;
    q_cmd.code   = in_ch.entry_code;
    q_cmd.rnd    = in_ch.random_value;
    case (in_ch.kind)
      wcp_pkg::KIND_CLEAR: begin
        q_cmd.op = wcp_pkg::OP_CLEAR;
      end
      wcp_pkg::KIND_ADD: begin
        if (!cat_ok) begin
          q_cmd.status = wcp_pkg::ST_BADCAT;
        end else if (in_ch.weight != '0) begin
          q_cmd.op = wcp_pkg::OP_ADD;
        end
      end
      wcp_pkg::KIND_PICK: begin
        if (!cat_ok) begin
          q_cmd.status = wcp_pkg::ST_BADCAT;
        end else begin
          q_cmd.op = wcp_pkg::OP_PICK;
        end
      end
      default: begin
        q_cmd.op = wcp_pkg::OP_REPORT;
      end
    endcase
  end

endmodule

/* rtl/wcp_queue.sv */
// Two-entry command queue between the front end and the back end.
// Depends on wcp_pkg for the command type.
module wcp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wcp_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output wcp_pkg::cmd_t  head
);

  wcp_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/wcp_back.sv */
// Back end: category totals, entry store, bit-serial modulo and store scan.
// Depends on wcp_pkg, wcp_out_if and assert_macros.svh.
`include "assert_macros.svh"
module wcp_back #(
  parameter int MAX_ENTRIES = 1024,
  parameter int NUM_CATS    = 85
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  wcp_pkg::cmd_t  q_head,
  output logic           q_pop,
  wcp_out_if.source      out_ch
);

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int CIW = (NUM_CATS > 1) ? $clog2(NUM_CATS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TOT  = 4'b0010,
    S_DIV  = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  wcp_pkg::cmd_t                cur_r, cur_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                ptr_r, ptr_nxt;
  logic                         pend_r, pend_nxt;
  logic [wcp_pkg::KEY_W-1:0]    tot_r, tot_nxt;
  logic [wcp_pkg::KEY_W-1:0]    rem_r, rem_nxt;
  logic [wcp_pkg::BIT_W-1:0]    bit_r, bit_nxt;
  logic [NUM_CATS-1:0]          vld_r, vld_nxt;
  logic                         out_valid_r, out_valid_nxt;
  wcp_pkg::status_t             out_status_r, out_status_nxt;
  logic [wcp_pkg::CODE_W-1:0]   out_code_r, out_code_nxt;

  logic [wcp_pkg::KEY_W-1:0]    tot_mem [NUM_CATS];
  logic [wcp_pkg::KEY_W-1:0]    tot_q;
  logic                         tot_hit_q;
  wcp_pkg::entry_t              ent_mem [MAX_ENTRIES];
  wcp_pkg::entry_t              ent_q;

  logic                         out_free;
  logic                         tot_rd;
  logic                         tot_we;
  logic [wcp_pkg::KEY_W-1:0]    tot_wdata;
  logic                         ent_we;
  logic                         ent_rd;
  logic [wcp_pkg::KEY_W-1:0]    cur_tot;
  logic [wcp_pkg::KEY_W:0]      shifted;
  logic                         hit;

  assign out_free           = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.picked_code = out_code_r;

  assign cur_tot = tot_hit_q ? tot_q : '0;
  assign shifted = {rem_r, cur_r.rnd[bit_r]};
  assign hit     = pend_r && (ent_q.cat == cur_r.cat) && (ent_q.key >= rem_r);

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = 1'b0;
    tot_nxt        = tot_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    vld_nxt        = vld_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_code_nxt   = out_code_r;
    q_pop          = 1'b0;
    tot_rd         = 1'b0;
    tot_we         = 1'b0;
    tot_wdata      = cur_tot + wcp_pkg::KEY_W'(cur_r.weight);
    ent_we         = 1'b0;
    ent_rd         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          case (q_head.op)
            wcp_pkg::OP_CLEAR: begin
              count_nxt      = '0;
              vld_nxt        = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = wcp_pkg::ST_OK;
              out_code_nxt   = '0;
            end
            wcp_pkg::OP_ADD, wcp_pkg::OP_PICK: begin
              tot_rd    = 1'b1;
              state_nxt = S_TOT;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = q_head.status;
              out_code_nxt   = '0;
            end
          endcase
        end
      end
      S_TOT: begin
        tot_nxt = cur_tot;
        if (cur_r.op == wcp_pkg::OP_ADD) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = '0;
          state_nxt     = S_IDLE;
          if (count_r == CW'(MAX_ENTRIES)) begin
            out_status_nxt = wcp_pkg::ST_FULL;
          end else begin
            out_status_nxt                 = wcp_pkg::ST_OK;
            tot_we                         = 1'b1;
            ent_we                         = 1'b1;
            vld_nxt[cur_r.cat[CIW-1:0]]    = 1'b1;
            count_nxt                      = count_r + 1'b1;
          end
        end else if (cur_tot == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = wcp_pkg::ST_EMPTY;
          out_code_nxt   = '0;
          state_nxt      = S_IDLE;
        end else begin
          rem_nxt   = '0;
          bit_nxt   = wcp_pkg::BIT_W'(wcp_pkg::RND_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // One quotient bit per cycle; the remainder stays below the total.
        if (shifted >= {1'b0, tot_r}) begin
          rem_nxt = wcp_pkg::KEY_W'(shifted - {1'b0, tot_r});
        end else begin
          rem_nxt = shifted[wcp_pkg::KEY_W-1:0];
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          ptr_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Reads are issued one per cycle; each compare sees the previous read.
        if (hit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = wcp_pkg::ST_OK;
          out_code_nxt   = ent_q.code;
          state_nxt      = S_IDLE;
        end else if (ptr_r < count_r) begin
          ent_rd   = 1'b1;
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + 1'b1;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = wcp_pkg::ST_EMPTY;
          out_code_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    ptr_r        <= ptr_nxt;
    tot_r        <= tot_nxt;
    rem_r        <= rem_nxt;
    bit_r        <= bit_nxt;
    out_status_r <= out_status_nxt;
    out_code_r   <= out_code_nxt;
  end

  always_ff @(posedge clk) begin
    if (tot_we) begin
      tot_mem[cur_r.cat[CIW-1:0]] <= tot_wdata;
    end
    if (tot_rd) begin
      tot_q     <= tot_mem[q_head.cat[CIW-1:0]];
      tot_hit_q <= vld_r[q_head.cat[CIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[count_r[AW-1:0]] <= '{cat: cur_r.cat, key: tot_wdata, code: cur_r.code};
    end
    if (ent_rd) begin
      ent_q <= ent_mem[ptr_r[AW-1:0]];
    end
  end

  `WCP_ASSERT_ALW(a_count_bound, clk, rst_n, count_r <= CW'(MAX_ENTRIES))
  `WCP_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, state_r == S_IDLE)
  `WCP_ASSERT_IMP(a_rem_below_tot, clk, rst_n, state_r == S_DIV || state_r == S_SCAN, rem_r < tot_r)

endmodule

/* test/wcp_checker.sv */
// Result checker for the weighted category pick block: watches both channels,
// predicts each result from the accepted beats and compares. Depends on wcp_pkg
// and the wcp_in_if and wcp_out_if interfaces.
module wcp_checker (
  input  logic  clk,
  input  logic  rst_n,
  wcp_in_if     in_mon,
  wcp_out_if    out_mon,
  output int    fail_count,
  output int    pending_count
);

  localparam int STORE_DEPTH = 1024;
  localparam int SLOT_COUNT  = 17;
  localparam int GRADE_COUNT = 5;
  localparam int CAT_COUNT   = SLOT_COUNT * GRADE_COUNT;

  typedef struct {
    wcp_pkg::status_t           status;
    logic [wcp_pkg::CODE_W-1:0] code;
  } pick_result_t;

  logic [wcp_pkg::CAT_W-1:0]  store_cat  [STORE_DEPTH];
  logic [wcp_pkg::KEY_W-1:0]  store_key  [STORE_DEPTH];
  logic [wcp_pkg::CODE_W-1:0] store_code [STORE_DEPTH];
  int                         stored;
  logic [wcp_pkg::KEY_W-1:0]  cat_total  [CAT_COUNT];
  pick_result_t               pending_results[$];

  assign pending_count = pending_results.size();

  // Works out the result of one accepted item and updates the predicted store.
  function automatic pick_result_t apply_item(wcp_pkg::kind_t kind, logic [2:0] grade,
                                              logic [4:0] slot,
                                              logic [wcp_pkg::WEIGHT_W-1:0] weight,
                                              logic [wcp_pkg::CODE_W-1:0] code,
                                              logic [wcp_pkg::RND_W-1:0] rnd);
    pick_result_t r;
    int unsigned cat;
    logic [wcp_pkg::KEY_W-1:0] target;
    r.status = wcp_pkg::ST_OK;
    r.code = '0;
    if (kind == wcp_pkg::KIND_CLEAR) begin
      stored = 0;
      foreach (cat_total[i]) cat_total[i] = '0;
    end else if (kind == wcp_pkg::KIND_ADD || kind == wcp_pkg::KIND_PICK) begin
      if (grade >= GRADE_COUNT || slot >= SLOT_COUNT) begin
        r.status = wcp_pkg::ST_BADCAT;
      end else begin
        cat = grade * SLOT_COUNT + slot;
        if (kind == wcp_pkg::KIND_ADD) begin
          if (weight != 0) begin
            if (stored >= STORE_DEPTH) begin
              r.status = wcp_pkg::ST_FULL;
            end else begin
              cat_total[cat] = cat_total[cat] + weight;
              store_cat[stored] = cat[wcp_pkg::CAT_W-1:0];
              store_key[stored] = cat_total[cat];
              store_code[stored] = code;
              stored++;
            end
          end
        end else if (cat_total[cat] == 0) begin
          r.status = wcp_pkg::ST_EMPTY;
        end else begin
          target = {1'b0, rnd} % cat_total[cat];
          r.status = wcp_pkg::ST_EMPTY;
          for (int i = 0; i < stored; i++) begin
            if (store_cat[i] == cat[wcp_pkg::CAT_W-1:0] && store_key[i] >= target) begin
              r.status = wcp_pkg::ST_OK;
              r.code = store_code[i];
              break;
            end
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pick_result_t want;
    if (!rst_n) begin
      stored = 0;
      foreach (cat_total[i]) cat_total[i] = '0;
      pending_results.delete();
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(apply_item(wcp_pkg::kind_t'(in_mon.kind), in_mon.grade,
                                             in_mon.slot, in_mon.weight,
                                             in_mon.entry_code, in_mon.random_value));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat: status %0d code %h",
                     out_mon.status, out_mon.picked_code);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (out_mon.status !== want.status || out_mon.picked_code !== want.code) begin
            if (fail_count < 10)
              $display("mismatch: expected status %0d code %h, got status %0d code %h",
                       want.status, want.code, out_mon.status, out_mon.picked_code);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* test/tb_weighted_category_pick_top.sv */
// Testbench top of the weighted category pick block: drives directed and random
// items with random idling on both sides and gives the verdict. Depends on wcp_pkg,
// the channel interfaces, wcp_checker and weighted_category_pick_top.
module tb_weighted_category_pick_top;

  localparam int RANDOM_ITEMS = 510;
  localparam int DRAIN_CYCLES = 1200;
  localparam int CYCLE_LIMIT  = 4000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cycle_count;

  wcp_in_if  in_ch ();
  wcp_out_if out_ch ();

  weighted_category_pick_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wcp_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver stalls at random at the current idle rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drives one beat; valid stays high across back-to-back beats.
  task automatic send(wcp_pkg::kind_t kind, logic [2:0] grade, logic [4:0] slot,
                      logic [wcp_pkg::WEIGHT_W-1:0] weight,
                      logic [wcp_pkg::CODE_W-1:0] code,
                      logic [wcp_pkg::RND_W-1:0] rnd);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.grade        <= grade;
    in_ch.slot         <= slot;
    in_ch.weight       <= weight;
    in_ch.entry_code   <= code;
    in_ch.random_value <= rnd;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(negedge clk);
      if (in_ch.ready) @(posedge clk);
      else @(posedge clk);
      if (in_ch.ready) break;
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Random item: mostly adds and picks on a few busy categories.
  task automatic send_random();
    int sel;
    wcp_pkg::kind_t kind;
    logic [2:0] grade;
    logic [4:0] slot;
    logic [wcp_pkg::WEIGHT_W-1:0] weight;
    logic [wcp_pkg::RND_W-1:0] rnd;
    sel = $urandom_range(99);
    kind = sel < 3 ? wcp_pkg::KIND_CLEAR : sel < 5 ? wcp_pkg::KIND_NONE :
           sel < 55 ? wcp_pkg::KIND_ADD : wcp_pkg::KIND_PICK;
    if ($urandom_range(99) < 8) begin
      grade = 3'($urandom_range(7));
      slot = 5'($urandom_range(31));
    end else if ($urandom_range(99) < 75) begin
      grade = 3'($urandom_range(1));
      slot = 5'($urandom_range(2));
    end else begin
      grade = 3'($urandom_range(4));
      slot = 5'($urandom_range(16));
    end
    sel = $urandom_range(9);
    weight = sel == 0 ? '0 : sel == 1 ? 7'd127 : 7'($urandom);
    sel = $urandom_range(9);
    rnd = sel == 0 ? '0 : sel == 1 ? '1 : sel < 5 ? 31'($urandom_range(600)) : 31'($urandom);
    send(kind, grade, slot, weight, $urandom, rnd);
  endtask

  initial begin
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.kind = wcp_pkg::KIND_CLEAR;
    in_ch.grade = '0;
    in_ch.slot = '0;
    in_ch.weight = '0;
    in_ch.entry_code = '0;
    in_ch.random_value = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, bad categories, unused kind, zero weight, code extremes.
    send(wcp_pkg::KIND_PICK, 3'd0, 5'd0, 7'd0, 32'd0, 31'd5);
    send(wcp_pkg::KIND_ADD, 3'd7, 5'd0, 7'd9, 32'd1, 31'd0);
    send(wcp_pkg::KIND_ADD, 3'd0, 5'd31, 7'd9, 32'd1, 31'd0);
    send(wcp_pkg::KIND_PICK, 3'd5, 5'd0, 7'd0, 32'd0, 31'd0);
    send(wcp_pkg::KIND_PICK, 3'd0, 5'd17, 7'd0, 32'd0, 31'd0);
    send(wcp_pkg::KIND_NONE, 3'd2, 5'd3, 7'd4, 32'hdead_beef, 31'd9);
    send(wcp_pkg::KIND_ADD, 3'd0, 5'd0, 7'd0, 32'h1234_5678, 31'd0);
    send(wcp_pkg::KIND_ADD, 3'd0, 5'd0, 7'd127, 32'h8000_0000, 31'd0);
    send(wcp_pkg::KIND_ADD, 3'd0, 5'd0, 7'd1, 32'h7fff_ffff, 31'd0);
    send(wcp_pkg::KIND_ADD, 3'd4, 5'd16, 7'd1, 32'hffff_ffff, 31'd0);
    send(wcp_pkg::KIND_ADD, 3'd4, 5'd16, 7'd3, 32'h0000_0001, 31'd0);
    send(wcp_pkg::KIND_PICK, 3'd0, 5'd0, 7'd0, 32'd0, 31'd0);
    send(wcp_pkg::KIND_PICK, 3'd0, 5'd0, 7'd0, 32'd0, 31'h7fff_ffff);
    send(wcp_pkg::KIND_PICK, 3'd0, 5'd0, 7'd0, 32'd0, 31'd127);
    send(wcp_pkg::KIND_PICK, 3'd0, 5'd0, 7'd0, 32'd0, 31'd128);
    send(wcp_pkg::KIND_PICK, 3'd4, 5'd16, 7'd0, 32'd0, 31'd1);
    send(wcp_pkg::KIND_PICK, 3'd4, 5'd16, 7'd0, 32'd0, 31'd4);
    send(wcp_pkg::KIND_PICK, 3'd1, 5'd0, 7'd0, 32'd0, 31'd3);
    send(wcp_pkg::KIND_CLEAR, 3'd0, 5'd0, 7'd0, 32'd0, 31'd0);
    send(wcp_pkg::KIND_PICK, 3'd0, 5'd0, 7'd0, 32'd0, 31'd1);
    wait_drained();

    send_idle_pct = 28;
    recv_idle_pct = 85;
    repeat (RANDOM_ITEMS / 3) send_random();
    wait_drained();

    send_idle_pct = 85;
    recv_idle_pct = 28;
    repeat (RANDOM_ITEMS / 3) send_random();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_ITEMS / 3) send_random();

    // Empty the store and check that it answers as empty afterwards.
    send(wcp_pkg::KIND_CLEAR, 3'd0, 5'd0, 7'd0, 32'd0, 31'd0);
    send(wcp_pkg::KIND_ADD, 3'd0, 5'd0, 7'd0, 32'd5, 31'd0);
    repeat (3) send(wcp_pkg::KIND_PICK, 3'($urandom_range(4)), 5'($urandom_range(16)),
                    7'd0, 32'd0, 31'($urandom));
    send(wcp_pkg::KIND_CLEAR, 3'd0, 5'd0, 7'd0, 32'd0, 31'd0);
    send(wcp_pkg::KIND_PICK, 3'd2, 5'd2, 7'd0, 32'd0, 31'd7);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
